### rtl/core/cursor_linked_list_manager_macros.svh
// Assertion macros for the cursor linked-list manager.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef CURSOR_LINKED_LIST_MANAGER_MACROS_SVH
`define CURSOR_LINKED_LIST_MANAGER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define CLLM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cllm check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLLM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cllm check failed");

`else

`define CLLM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CLLM_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/cllm_pkg.sv
// Shared constants and types for the cursor linked-list manager.
// No dependencies; used by the interfaces, the node pool and the top level.
package cllm_pkg;

    localparam int NODES     = 128;
    localparam int KEY_WIDTH = 64;
    localparam int IDX_W     = $clog2(NODES);
    localparam int STEP_W    = IDX_W + 1;

    // Fixed field widths of the channels
    localparam int CMD_W    = 2;
    localparam int HEAD_W   = 7;
    localparam int KEY_IN_W = 64;
    localparam int STAT_W   = 2;

    localparam logic [CMD_W-1:0] CMD_NEW    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_FREE   = 2'd2;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [STEP_W-1:0]    step_t;

    // One access to the node pool: a write to link and/or key, and a read
    typedef struct packed {
        logic link_we;
        logic key_we;
        idx_t wr_addr;
        idx_t link_wd;
        key_t key_wd;
        idx_t rd_addr;
    } pool_req_t;

endpackage

### rtl/core/cllm_if.sv
// Request and result channels of the cursor linked-list manager.
// Depends on cllm_pkg for the field widths.
interface cllm_req_if import cllm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [HEAD_W-1:0]   list_head;
    logic [KEY_IN_W-1:0] key;

    modport source (output valid, output cmd, output list_head, output key, input ready);
    modport sink   (input valid, input cmd, input list_head, input key, output ready);
endinterface

interface cllm_rsp_if import cllm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [HEAD_W-1:0] node_index;
    logic              is_empty;

    modport source (output valid, output status, output node_index, output is_empty,
                    input ready);
    modport sink   (input valid, input status, input node_index, input is_empty,
                    output ready);
endinterface

### rtl/core/cllm_pool.sv
// Node pool: link and key memories, one write and one registered read each.
// Depends on cllm_pkg for the access struct and widths.
module cllm_pool import cllm_pkg::*;
(
    input  logic      clk,
    input  pool_req_t acc,
    output idx_t      link_rd,
    output key_t      key_rd
);

    idx_t link_mem [NODES];
    key_t key_mem  [NODES];

    idx_t link_rd_reg;
    key_t key_rd_reg;

    // Read returns the old contents when the same entry is written that cycle
    always_ff @(posedge clk)
    begin
        if (acc.link_we)
        begin
            link_mem[acc.wr_addr] <= acc.link_wd;
        end
        link_rd_reg <= link_mem[acc.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (acc.key_we)
        begin
            key_mem[acc.wr_addr] <= acc.key_wd;
        end
        key_rd_reg <= key_mem[acc.rd_addr];
    end

    assign link_rd = link_rd_reg;
    assign key_rd  = key_rd_reg;

endmodule

### rtl/core/cursor_linked_list_manager.sv
// Cursor linked-list manager: a pool of NODES nodes in synchronous memory, node 0
// heading the free list. One request is handled at a time. After reset a sweep
// chains the free list, with req.ready low. An append walks the list node by node
// to its tail, and a delete compares keys node by node until a match or the end.
// The walk runs one node per cycle because each next address comes out of the
// previous registered read of the link memory. The result sits in an output
// register, so the next request is taken while it waits; a request reaching its
// last cycle stays there while the previous result is still held.
// Depends on cllm_pkg, cllm_if, cllm_pool and the assertion macro header.
`include "cursor_linked_list_manager_macros.svh"

module cursor_linked_list_manager import cllm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cllm_req_if.sink    req,
    cllm_rsp_if.source  rsp
);

    localparam logic [3:0] ST_INIT      = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_TAKE_F    = 4'd2;
    localparam logic [3:0] ST_TAKE_G    = 4'd3;
    localparam logic [3:0] ST_TAKE_LINK = 4'd4;
    localparam logic [3:0] ST_TAKE_CLR  = 4'd5;
    localparam logic [3:0] ST_AP_WALK   = 4'd6;
    localparam logic [3:0] ST_DL_START  = 4'd7;
    localparam logic [3:0] ST_DL_WALK   = 4'd8;
    localparam logic [3:0] ST_DL_UNLINK = 4'd9;
    localparam logic [3:0] ST_DL_FREE   = 4'd10;
    localparam logic [3:0] ST_DL_PUSH   = 4'd11;
    localparam logic [3:0] ST_EMPTY_RD  = 4'd12;
    localparam logic [3:0] ST_EMPTY_WT  = 4'd13;
    localparam logic [3:0] ST_DONE      = 4'd14;

    logic [3:0]        state_reg, state_next;
    idx_t              init_cnt_reg, init_cnt_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    idx_t              head_reg, head_next;
    key_t              key_reg, key_next;
    idx_t              p_reg, p_next;
    idx_t              nx_reg, nx_next;
    idx_t              fresh_reg, fresh_next;
    step_t             steps_reg, steps_next;
    logic [STAT_W-1:0] status_reg, status_next;
    idx_t              idx_reg, idx_next;
    logic              empty_reg, empty_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0] rsp_status_reg, rsp_status_next;
    logic [HEAD_W-1:0] rsp_index_reg, rsp_index_next;
    logic              rsp_empty_reg, rsp_empty_next;

    pool_req_t acc;
    idx_t      link_rd;
    key_t      key_rd;
    step_t     steps_inc;
    logic      head_ok;

    cllm_pool u_pool
    (
        .clk     (clk),
        .acc     (acc),
        .link_rd (link_rd),
        .key_rd  (key_rd)
    );

    assign steps_inc = steps_reg + step_t'(1);
    assign head_ok   = (req.list_head != '0) && (32'(req.list_head) < 32'(NODES));
    assign req.ready = (state_reg == ST_IDLE);

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.node_index = rsp_index_reg;
    assign rsp.is_empty   = rsp_empty_reg;

    always_comb
    begin
        state_next      = state_reg;
        init_cnt_next   = init_cnt_reg;
        cmd_next        = cmd_reg;
        head_next       = head_reg;
        key_next        = key_reg;
        p_next          = p_reg;
        nx_next         = nx_reg;
        fresh_next      = fresh_reg;
        steps_next      = steps_reg;
        status_next     = status_reg;
        idx_next        = idx_reg;
        empty_next      = empty_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_index_next  = rsp_index_reg;
        rsp_empty_next  = rsp_empty_reg;
        acc             = '0;

        case (state_reg)
            ST_INIT:
            begin
                acc.link_we = 1'b1;
                acc.wr_addr = init_cnt_reg;
                if (init_cnt_reg == IDX_W'(NODES - 1))
                begin
                    acc.link_wd = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    acc.link_wd   = init_cnt_reg + idx_t'(1);
                    init_cnt_next = init_cnt_reg + idx_t'(1);
                end
            end

            ST_IDLE:
            begin
                acc.rd_addr = (req.cmd == CMD_NEW) ? '0 : IDX_W'(req.list_head);
                if (req.valid)
                begin
                    cmd_next    = req.cmd;
                    head_next   = IDX_W'(req.list_head);
                    p_next      = IDX_W'(req.list_head);
                    key_next    = req.key[KEY_WIDTH-1:0];
                    steps_next  = '0;
                    status_next = STAT_DONE;
                    idx_next    = '0;
                    empty_next  = 1'b1;
                    if (req.cmd == CMD_NEW)
                    begin
                        state_next = ST_TAKE_F;
                    end
                    else if (!head_ok)
                    begin
                        status_next = STAT_NOT_FOUND;
                        state_next  = ST_DONE;
                    end
                    else if (req.cmd == CMD_APPEND)
                    begin
                        state_next = ST_AP_WALK;
                    end
                    else if (req.cmd == CMD_DELETE)
                    begin
                        state_next = ST_DL_START;
                    end
                    else
                    begin
                        state_next = ST_EMPTY_WT;
                    end
                end
            end

            // walk to the tail; bounded so a corrupted chain cannot hang
            ST_AP_WALK:
            begin
                if ((link_rd != '0) && (steps_reg < STEP_W'(NODES)))
                begin
                    p_next      = link_rd;
                    steps_next  = steps_inc;
                    acc.rd_addr = link_rd;
                end
                else
                begin
                    acc.rd_addr = '0;
                    state_next  = ST_TAKE_F;
                end
            end

            ST_TAKE_F:
            begin
                fresh_next = link_rd;
                if (link_rd == '0)
                begin
                    status_next = STAT_NO_FREE;
                    state_next  = (cmd_reg == CMD_NEW) ? ST_DONE : ST_EMPTY_RD;
                end
                else
                begin
                    acc.rd_addr = link_rd;
                    state_next  = ST_TAKE_G;
                end
            end

            ST_TAKE_G:
            begin
                acc.link_we = 1'b1;
                acc.wr_addr = '0;
                acc.link_wd = link_rd;
                state_next  = (cmd_reg == CMD_NEW) ? ST_TAKE_CLR : ST_TAKE_LINK;
            end

            // tail equal to the fresh node only on a corrupted chain; its link ends 0
            ST_TAKE_LINK:
            begin
                acc.link_we = (p_reg != fresh_reg);
                acc.wr_addr = p_reg;
                acc.link_wd = fresh_reg;
                state_next  = ST_TAKE_CLR;
            end

            ST_TAKE_CLR:
            begin
                acc.link_we = 1'b1;
                acc.key_we  = (cmd_reg == CMD_APPEND);
                acc.wr_addr = fresh_reg;
                acc.link_wd = '0;
                acc.key_wd  = key_reg;
                idx_next    = fresh_reg;
                state_next  = (cmd_reg == CMD_NEW) ? ST_DONE : ST_EMPTY_RD;
            end

            ST_DL_START:
            begin
                if (link_rd != '0)
                begin
                    nx_next     = link_rd;
                    acc.rd_addr = link_rd;
                    state_next  = ST_DL_WALK;
                end
                else
                begin
                    status_next = STAT_NOT_FOUND;
                    state_next  = ST_EMPTY_RD;
                end
            end

            // link_rd and key_rd both belong to nx_reg here
            ST_DL_WALK:
            begin
                if (key_rd == key_reg)
                begin
                    fresh_next = nx_reg;
                    nx_next    = link_rd;
                    state_next = ST_DL_UNLINK;
                end
                else
                begin
                    p_next     = nx_reg;
                    steps_next = steps_inc;
                    if ((link_rd != '0) && (steps_inc < STEP_W'(NODES)))
                    begin
                        nx_next     = link_rd;
                        acc.rd_addr = link_rd;
                    end
                    else
                    begin
                        status_next = STAT_NOT_FOUND;
                        state_next  = ST_EMPTY_RD;
                    end
                end
            end

            ST_DL_UNLINK:
            begin
                acc.link_we = 1'b1;
                acc.wr_addr = p_reg;
                acc.link_wd = nx_reg;
                acc.rd_addr = '0;
                state_next  = ST_DL_FREE;
            end

            ST_DL_FREE:
            begin
                acc.link_we = 1'b1;
                acc.wr_addr = fresh_reg;
                acc.link_wd = link_rd;
                state_next  = ST_DL_PUSH;
            end

            ST_DL_PUSH:
            begin
                acc.link_we = 1'b1;
                acc.wr_addr = '0;
                acc.link_wd = fresh_reg;
                idx_next    = fresh_reg;
                state_next  = ST_EMPTY_RD;
            end

            ST_EMPTY_RD:
            begin
                acc.rd_addr = head_reg;
                state_next  = ST_EMPTY_WT;
            end

            ST_EMPTY_WT:
            begin
                empty_next = (link_rd == '0);
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_index_next  = HEAD_W'(idx_reg);
                    rsp_empty_next  = empty_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        head_reg       <= head_next;
        key_reg        <= key_next;
        p_reg          <= p_next;
        nx_reg         <= nx_next;
        fresh_reg      <= fresh_next;
        steps_reg      <= steps_next;
        status_reg     <= status_next;
        idx_reg        <= idx_next;
        empty_reg      <= empty_next;
        rsp_status_reg <= rsp_status_next;
        rsp_index_reg  <= rsp_index_next;
        rsp_empty_reg  <= rsp_empty_next;
    end

    // failures never report a node
    `CLLM_ASSERT_IMP(a_fail_no_index, clk, rst_n, rsp_valid_reg && (rsp_status_reg != STAT_DONE), rsp_index_reg == '0)
    // walk counter stays within its bound
    `CLLM_ASSERT_IMP(a_steps_bound, clk, rst_n, state_reg != ST_INIT && state_reg != ST_IDLE, steps_reg <= STEP_W'(NODES))
    // link writes never point outside the pool
    `CLLM_ASSERT_IMP(a_link_range, clk, rst_n, acc.link_we, 32'(acc.link_wd) < 32'(NODES))
    // an accepted request always leaves idle
    `CLLM_ASSERT_NXT(a_accept_busy, clk, rst_n, state_reg == ST_IDLE && req.valid, state_reg != ST_IDLE)
    // a result is only loaded while a request is finishing
    `CLLM_ASSERT_NXT(a_load_from_done, clk, rst_n, !rsp_valid_reg && state_reg != ST_DONE, !rsp_valid_reg)

endmodule

### verif/cursor_linked_list_manager_tb.sv
// Self-checking testbench for the cursor linked-list manager: request driver,
// result monitor and an in-order predictor of the node pool and its free list.
// Depends on cllm_pkg, the cllm_req_if / cllm_rsp_if interfaces and the top level.
`timescale 1ns / 1ps

module cursor_linked_list_manager_tb import cllm_pkg::*; ();

    localparam int PLAN = 0;   // copy of the pool used while building stimulus
    localparam int LIVE = 1;   // copy advanced on each accepted request

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [HEAD_W-1:0]   head;
        logic [KEY_IN_W-1:0] key;
        logic                hold;   // wait for every result before sending
    } list_request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [HEAD_W-1:0] node_index;
        logic              is_empty;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                drv_valid = 1'b0;
    logic [CMD_W-1:0]    drv_cmd = CMD_QUERY;
    logic [HEAD_W-1:0]   drv_head = '0;
    logic [KEY_IN_W-1:0] drv_key = '0;
    logic                snk_ready = 1'b0;

    idx_t chain_link [2][NODES];
    key_t chain_key  [2][NODES];
    bit   key_valid  [2][NODES];

    list_request_t request_queue[$];
    list_result_t  pending_results[$];
    list_result_t  oldest;
    int            src_gap;
    int            sink_stall;
    int            fail_count = 0;

    cllm_req_if req_ch ();
    cllm_rsp_if rsp_ch ();

    assign req_ch.valid     = drv_valid;
    assign req_ch.cmd       = drv_cmd;
    assign req_ch.list_head = drv_head;
    assign req_ch.key       = drv_key;
    assign rsp_ch.ready     = snk_ready;

    cursor_linked_list_manager u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #15_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic idx_t take_node(int s);
        idx_t p;
        p = chain_link[s][0];
        if (p != 0)
        begin
            chain_link[s][0] = chain_link[s][p];
            chain_link[s][p] = '0;
        end
        return p;
    endfunction

    // Applies one request to pool copy s and returns the result it yields
    function automatic list_result_t serve_request(int s, list_request_t r);
        list_result_t res;
        idx_t         head;
        idx_t         p;
        idx_t         nx;
        idx_t         fresh;
        key_t         k;
        int           steps;
        bit           found;
        res.status     = STAT_DONE;
        res.node_index = '0;
        res.is_empty   = 1'b1;
        head           = idx_t'(r.head);
        k              = key_t'(r.key);
        if (r.cmd == CMD_NEW)
        begin
            fresh = take_node(s);
            if (fresh == 0)
                res.status = STAT_NO_FREE;
            else
                res.node_index = fresh;
        end
        else if (r.head == 0 || int'(r.head) >= NODES)
        begin
            res.status = STAT_NOT_FOUND;
        end
        else
        begin
            if (r.cmd == CMD_APPEND)
            begin
                p     = head;
                steps = 0;
                while (chain_link[s][p] != 0 && steps < NODES)
                begin
                    p = chain_link[s][p];
                    steps++;
                end
                fresh = take_node(s);
                if (fresh == 0)
                    res.status = STAT_NO_FREE;
                else
                begin
                    // order matters when the tail and the fresh node coincide
                    chain_link[s][p]     = fresh;
                    chain_link[s][fresh] = '0;
                    chain_key[s][fresh]  = k;
                    key_valid[s][fresh]  = 1'b1;
                    res.node_index       = fresh;
                end
            end
            else if (r.cmd == CMD_DELETE)
            begin
                found = 1'b0;
                p     = head;
                steps = 0;
                while (chain_link[s][p] != 0 && steps < NODES && !found)
                begin
                    nx = chain_link[s][p];
                    if (chain_key[s][nx] == k)
                        found = 1'b1;
                    else
                    begin
                        p = nx;
                        steps++;
                    end
                end
                if (found)
                begin
                    nx                = chain_link[s][p];
                    chain_link[s][p]  = chain_link[s][nx];
                    chain_link[s][nx] = chain_link[s][0];
                    chain_link[s][0]  = nx;
                    res.node_index    = nx;
                end
                else
                    res.status = STAT_NOT_FOUND;
            end
            res.is_empty = (chain_link[s][head] == 0);
        end
        return res;
    endfunction

    // Queues one request and advances the planning copy; a delete whose walk
    // could land on a never-written key is turned into a query
    function automatic list_result_t queue_request(logic [CMD_W-1:0] cmd,
                                                   logic [HEAD_W-1:0] head,
                                                   logic [KEY_IN_W-1:0] key,
                                                   logic hold);
        list_request_t item;
        idx_t          p;
        int            steps;
        bit            unsafe;
        unsafe = 1'b0;
        if (cmd == CMD_DELETE && head != 0)
        begin
            p     = idx_t'(head);
            steps = 0;
            while (chain_link[PLAN][p] != 0 && steps < NODES)
            begin
                p = chain_link[PLAN][p];
                if (!key_valid[PLAN][p])
                    unsafe = 1'b1;
                steps++;
            end
        end
        item.cmd  = unsafe ? CMD_QUERY : cmd;
        item.head = head;
        item.key  = key;
        item.hold = hold;
        request_queue.push_back(item);
        return serve_request(PLAN, item);
    endfunction

    function automatic logic [KEY_IN_W-1:0] pick_key();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return 64'h1;
            3:       return 64'h8000_0000_0000_0000;
            4:       return 64'h5A5A_5A5A_A5A5_A5A5;
            5:       return 64'h0123_4567_89AB_CDEF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // No idling near the end of the run, and in periodic stretches before it
    function automatic bit idle_free();
        return request_queue.size() < 150 || (request_queue.size() / 100) % 5 == 2;
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_cmd   <= CMD_QUERY;
            drv_head  <= '0;
            drv_key   <= '0;
            src_gap   <= 0;
        end
        else
        begin
            if (drv_valid && req_ch.ready)
            begin
                pending_results.push_back(serve_request(LIVE, request_queue[0]));
                void'(request_queue.pop_front());
            end
            if (drv_valid && !req_ch.ready)
            begin
                // request still waiting: hold it
            end
            else if (src_gap != 0)
            begin
                src_gap   <= src_gap - 1;
                drv_valid <= 1'b0;
            end
            else if (request_queue.size() == 0 ||
                     (request_queue[0].hold && pending_results.size() != 0))
            begin
                drv_valid <= 1'b0;
            end
            else if (!idle_free() && $urandom_range(0, 7) == 0)
            begin
                src_gap   <= $urandom_range(1, 19) - 1;
                drv_valid <= 1'b0;
            end
            else
            begin
                drv_valid <= 1'b1;
                drv_cmd   <= request_queue[0].cmd;
                drv_head  <= request_queue[0].head;
                drv_key   <= request_queue[0].key;
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snk_ready  <= 1'b0;
            sink_stall <= 0;
        end
        else
        begin
            if (rsp_ch.valid && snk_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: status %0d node_index %0d is_empty %0d",
                           rsp_ch.status, rsp_ch.node_index, rsp_ch.is_empty);
                    fail_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (rsp_ch.status !== oldest.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.node_index !== oldest.node_index)
                    begin
                        $error("node_index: expected %0d, got %0d",
                               oldest.node_index, rsp_ch.node_index);
                        fail_count++;
                    end
                    if (rsp_ch.is_empty !== oldest.is_empty)
                    begin
                        $error("is_empty: expected %0d, got %0d",
                               oldest.is_empty, rsp_ch.is_empty);
                        fail_count++;
                    end
                end
            end
            if (sink_stall != 0)
            begin
                sink_stall <= sink_stall - 1;
                snk_ready  <= 1'b0;
            end
            else if (!idle_free() && $urandom_range(0, 9) == 0)
            begin
                sink_stall <= $urandom_range(1, 19) - 1;
                snk_ready  <= 1'b0;
            end
            else
                snk_ready <= 1'b1;
        end
    end

    // Stimulus and end of run
    initial
    begin
        list_result_t      r;
        logic [HEAD_W-1:0] list_heads[$];
        logic [HEAD_W-1:0] h;
        logic [HEAD_W-1:0] h2;
        key_t              seen_keys[$];
        idx_t              p;
        int                steps;
        int                free_cnt;
        int                roll;
        bit                fill_mode;
        logic              hold;

        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                chain_link[s][i] = idx_t'((i + 1) % NODES);
                chain_key[s][i]  = '0;
                key_valid[s][i]  = 1'b0;
            end
        end

        // bad header on every command that takes one
        void'(queue_request(CMD_QUERY, 7'd0, '0, 1'b0));
        void'(queue_request(CMD_APPEND, 7'd0, '1, 1'b0));
        void'(queue_request(CMD_DELETE, 7'd0, '1, 1'b0));
        r  = queue_request(CMD_NEW, 7'h7F, '1, 1'b0);
        h  = r.node_index;
        r  = queue_request(CMD_NEW, 7'd0, '0, 1'b0);
        h2 = r.node_index;
        list_heads.push_back(h);
        list_heads.push_back(h2);
        void'(queue_request(CMD_QUERY, h, '0, 1'b0));
        void'(queue_request(CMD_DELETE, h, '0, 1'b0));
        void'(queue_request(CMD_APPEND, h, '0, 1'b0));
        void'(queue_request(CMD_APPEND, h, '1, 1'b0));
        void'(queue_request(CMD_APPEND, h, '0, 1'b0));
        void'(queue_request(CMD_APPEND, h2, 64'h5555_5555_5555_5555, 1'b0));
        void'(queue_request(CMD_APPEND, h2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0));
        void'(queue_request(CMD_QUERY, h, '0, 1'b0));
        // duplicate keys: first match in list order goes first
        void'(queue_request(CMD_DELETE, h, '0, 1'b0));
        void'(queue_request(CMD_DELETE, h, '0, 1'b0));
        void'(queue_request(CMD_DELETE, h, '0, 1'b0));
        void'(queue_request(CMD_DELETE, h, '1, 1'b0));
        void'(queue_request(CMD_QUERY, 7'h7F, '1, 1'b0));
        void'(queue_request(CMD_DELETE, 7'h7F, '0, 1'b0));
        void'(queue_request(CMD_DELETE, h2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0));
        void'(queue_request(CMD_QUERY, h2, '0, 1'b0));

        fill_mode = 1'b1;
        for (int n = 0; n < 1650; n++)
        begin
            p        = chain_link[PLAN][0];
            free_cnt = 0;
            while (p != 0 && free_cnt < NODES)
            begin
                free_cnt++;
                p = chain_link[PLAN][p];
            end
            if (free_cnt == 0 && fill_mode)
            begin
                // pool exhausted: both allocating commands must fail
                fill_mode = 1'b0;
                void'(queue_request(CMD_NEW, 7'd0, pick_key(), 1'b0));
                h = list_heads[$urandom_range(0, list_heads.size() - 1)];
                void'(queue_request(CMD_APPEND, h, pick_key(), 1'b0));
                continue;
            end
            if (!fill_mode && free_cnt >= 100)
                fill_mode = 1'b1;
            hold = (n % 400 == 0);
            roll = $urandom_range(0, 99);
            if (roll < 15)
            begin
                void'(queue_request(CMD_W'($urandom_range(0, 3)), HEAD_W'($urandom_range(0, 127)),
                                    {$urandom, $urandom}, hold));
            end
            else if (roll < 15 + (list_heads.size() < 10 ? 8 : 1))
            begin
                r = queue_request(CMD_NEW, HEAD_W'($urandom_range(0, 127)), pick_key(), hold);
                if (r.status == STAT_DONE)
                    list_heads.push_back(r.node_index);
            end
            else
            begin
                h    = list_heads[$urandom_range(0, list_heads.size() - 1)];
                roll = $urandom_range(0, 99);
                if (roll < (fill_mode ? 65 : 15))
                    void'(queue_request(CMD_APPEND, h, pick_key(), hold));
                else if (roll < 85)
                begin
                    seen_keys.delete();
                    p     = chain_link[PLAN][h];
                    steps = 0;
                    while (p != 0 && steps < NODES)
                    begin
                        seen_keys.push_back(chain_key[PLAN][p]);
                        p = chain_link[PLAN][p];
                        steps++;
                    end
                    if (seen_keys.size() != 0 && $urandom_range(0, 3) != 0)
                        void'(queue_request(CMD_DELETE, h,
                                            seen_keys[$urandom_range(0, seen_keys.size() - 1)],
                                            hold));
                    else
                        void'(queue_request(CMD_DELETE, h, pick_key(), hold));
                end
                else
                    void'(queue_request(CMD_QUERY, h, pick_key(), hold));
            end
        end

        while (request_queue.size() != 0)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (NODES + 16) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
